// ===== src/psqst_pkg.sv =====
// Types and constants shared by the quote statistics table.
// No dependencies; every other file in src refers to this package by scoped name.
package psqst_pkg;

  localparam int unsigned SYM_W   = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SLOT_W  = 6;   // width of the report slot field
  localparam int unsigned STAT_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_REPORT  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic [SYM_W-1:0]   symbol;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [TIME_W-1:0]  send_time;
    logic [TIME_W-1:0]  now_time;
    logic [SLOT_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SYM_W-1:0]   symbol_out;
    logic [PRICE_W-1:0] bid_top;
    logic [PRICE_W-1:0] ask_top;
    logic [PRICE_W-1:0] spread;
    logic [VOL_W-1:0]   volume;
    logic [CNT_W-1:0]   msg_total;
    logic [CNT_W-1:0]   processed_count;
    logic [TIME_W-1:0]  latency_total;
  } rsp_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    logic               ask_seen;
    logic [VOL_W-1:0]   volume;
    logic [CNT_W-1:0]   count;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic match;
    logic group;
    logic select;
    logic read;
    logic write;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_report;
  } sts_t;

endpackage

// ===== src/psqst_ctrl.sv =====
// Sequencing controller for the quote statistics table.
// Depends on psqst_pkg for the command and status structs.
module psqst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  psqst_pkg::sts_t   sts_i,
  output psqst_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_SELECT,
    S_READ,
    S_WRITE,
    S_EMIT
  } state_e;

  state_e          state_q, state_d;
  psqst_pkg::cmd_t cmd_q, cmd_d;
  logic            busy_q;
  logic            capture;

  assign capture = start & ~busy_q;
  assign busy    = busy_q;

  always_comb begin
    cmd_o         = cmd_q;
    cmd_o.capture = capture;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (capture) state_d = S_MATCH;
      // reports need no symbol search
      S_MATCH:  state_d = sts_i.is_report ? S_SELECT : S_GROUP;
      S_GROUP:  state_d = S_SELECT;
      S_SELECT: state_d = S_READ;
      S_READ:   state_d = S_WRITE;
      S_WRITE:  state_d = S_EMIT;
      S_EMIT:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d         = '0;
    cmd_d.match   = (state_d == S_MATCH);
    cmd_d.group   = (state_d == S_GROUP);
    cmd_d.select  = (state_d == S_SELECT);
    cmd_d.read    = (state_d == S_READ);
    cmd_d.write   = (state_d == S_WRITE);
    cmd_d.emit    = (state_d == S_EMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

endmodule

// ===== src/psqst_cam.sv =====
// Symbol store with per-slot comparators and a two-level registered encoder.
// Depends on psqst_pkg for the symbol width.
module psqst_cam #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic [psqst_pkg::SYM_W-1:0]   key_i,
  input  logic [$clog2(SLOTS+1)-1:0]    fill_i,
  input  logic                          match_en_i,
  input  logic                          group_en_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(SLOTS)-1:0]      wr_idx_i,
  input  logic [psqst_pkg::SYM_W-1:0]   wr_key_i,
  output logic                          hit_o,
  output logic [$clog2(SLOTS)-1:0]      hit_idx_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned FILL_W = $clog2(SLOTS + 1);
  localparam int unsigned GRP    = 32;
  localparam int unsigned LW     = $clog2(GRP);
  localparam int unsigned NG     = (SLOTS + GRP - 1) / GRP;

  logic [psqst_pkg::SYM_W-1:0] sym_q [SLOTS];
  logic [SLOTS-1:0]            match_q;
  logic [NG*GRP-1:0]           match_all;
  logic [NG-1:0]               grp_hit_q;
  logic [LW-1:0]               grp_idx_q [NG];

  assign match_all = (NG*GRP)'(match_q);

  // slots below the fill count are the live ones
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (wr_en_i && wr_idx_i == IDX_W'(i)) sym_q[i] <= wr_key_i;
      if (match_en_i) match_q[i] <= (FILL_W'(i) < fill_i) && (sym_q[i] == key_i);
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic          ghit;
    logic [LW-1:0] gidx;
    always_comb begin
      ghit = 1'b0;
      gidx = '0;
      for (int j = 0; j < GRP; j++) begin
        if (match_all[g*GRP+j]) begin
          ghit = 1'b1;
          gidx = gidx | LW'(j);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (group_en_i) begin
        grp_hit_q[g] <= ghit;
        grp_idx_q[g] <= gidx;
      end
    end
  end

  // at most one live slot carries a given key, so the index is an OR
  always_comb begin
    hit_idx_o = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_hit_q[g]) hit_idx_o = hit_idx_o | IDX_W'(g*GRP) | IDX_W'(grp_idx_q[g]);
    end
  end

  assign hit_o = |grp_hit_q;

endmodule

// ===== src/psqst_dp.sv =====
// Datapath: request capture, key formation, slot memory, update and result register.
// Depends on psqst_pkg and instantiates psqst_cam.
module psqst_dp #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned SYM_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psqst_pkg::req_t   req_i,
  input  psqst_pkg::cmd_t   cmd_i,
  output psqst_pkg::sts_t   sts_o,
  output logic              done_o,
  output psqst_pkg::rsp_t   result_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned FILL_W = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W  = (FILL_W > psqst_pkg::SLOT_W) ? FILL_W : psqst_pkg::SLOT_W;
  localparam int unsigned SYM_W  = psqst_pkg::SYM_W;
  localparam int unsigned PR_W   = psqst_pkg::PRICE_W;
  localparam int unsigned VOL_W  = psqst_pkg::VOL_W;
  localparam int unsigned CNT_W  = psqst_pkg::CNT_W;
  localparam int unsigned TIME_W = psqst_pkg::TIME_W;

  psqst_pkg::req_t    req_q;
  logic [SYM_W-1:0]   key_d, key_q;
  logic [TIME_W-1:0]  lat_diff_q;
  logic               lat_ok_q;
  logic [FILL_W-1:0]  fill_q;
  logic [CNT_W-1:0]   handled_q;
  logic [TIME_W-1:0]  lat_sum_q;
  logic [IDX_W-1:0]   idx_q;
  psqst_pkg::status_e status_q;
  psqst_pkg::slot_t   ram_q [SLOTS];
  psqst_pkg::slot_t   rd_q;
  psqst_pkg::slot_t   upd_q;
  psqst_pkg::slot_t   base, nxt;
  psqst_pkg::slot_t   drop_slot;
  psqst_pkg::rsp_t    result_q;
  logic               done_q;
  logic               cam_hit;
  logic [IDX_W-1:0]   cam_idx;
  logic [CMP_W-1:0]   rep_ext;
  logic [VOL_W:0]     vol_sum;
  logic [TIME_W:0]    lat_add;
  logic [PR_W-1:0]    ask_vis;
  logic [PR_W-1:0]    spread;

  // key: bytes up to the first zero byte and within the symbol length
  always_comb begin
    logic keep;
    keep  = 1'b1;
    key_d = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < SYM_BYTES && keep && req_i.symbol[i*8 +: 8] != 8'd0) begin
        key_d[i*8 +: 8] = req_i.symbol[i*8 +: 8];
      end else begin
        keep = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      key_q <= key_d;
    end
    if (cmd_i.match) begin
      lat_diff_q <= req_q.now_time - req_q.send_time;
      lat_ok_q   <= (req_q.now_time >= req_q.send_time);
    end
  end

  assign sts_o.is_report = req_q.req_type;

  psqst_cam #(
    .SLOTS (SLOTS)
  ) u_cam (
    .clk_i      (clk_i),
    .key_i      (key_q),
    .fill_i     (fill_q),
    .match_en_i (cmd_i.match),
    .group_en_i (cmd_i.group),
    .wr_en_i    (cmd_i.write && status_q == psqst_pkg::ST_NEW),
    .wr_idx_i   (idx_q),
    .wr_key_i   (key_q),
    .hit_o      (cam_hit),
    .hit_idx_o  (cam_idx)
  );

  assign rep_ext = CMP_W'(req_q.slot_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      if (req_q.req_type) begin
        idx_q    <= IDX_W'(rep_ext);
        status_q <= (rep_ext < CMP_W'(fill_q)) ? psqst_pkg::ST_REPORT : psqst_pkg::ST_EMPTY;
      end else if (cam_hit) begin
        idx_q    <= cam_idx;
        status_q <= psqst_pkg::ST_UPDATED;
      end else if (fill_q < FILL_W'(SLOTS)) begin
        idx_q    <= IDX_W'(fill_q);
        status_q <= psqst_pkg::ST_NEW;
      end else begin
        idx_q    <= '0;
        status_q <= psqst_pkg::ST_FULL;
      end
    end
  end

  // slot memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) rd_q <= ram_q[idx_q];
    if (cmd_i.write && (status_q == psqst_pkg::ST_UPDATED || status_q == psqst_pkg::ST_NEW)) begin
      ram_q[idx_q] <= nxt;
    end
  end

  // read-modify-write of the selected slot
  always_comb begin
    base = (status_q == psqst_pkg::ST_NEW) ? '0 : rd_q;
    nxt  = base;
    nxt.symbol = key_q;
    if (base.count != '1) nxt.count = base.count + CNT_W'(1);
    vol_sum    = {1'b0, base.volume} + (VOL_W+1)'(req_q.quantity);
    nxt.volume = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
    if (!req_q.side) begin
      if (req_q.price > base.bid) nxt.bid = req_q.price;
    end else if (!base.ask_seen || req_q.price < base.ask) begin
      nxt.ask      = req_q.price;
      nxt.ask_seen = 1'b1;
    end
  end

  // dropped update: of the slot fields only the key is reported
  always_comb begin
    drop_slot        = '0;
    drop_slot.symbol = key_q;
  end

  assign lat_add = {1'b0, lat_sum_q} + {1'b0, lat_diff_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      case (status_q)
        psqst_pkg::ST_UPDATED, psqst_pkg::ST_NEW: upd_q <= nxt;
        psqst_pkg::ST_REPORT:                     upd_q <= rd_q;
        psqst_pkg::ST_FULL:                       upd_q <= drop_slot;
        default:                                  upd_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      handled_q <= '0;
      lat_sum_q <= '0;
    end else if (cmd_i.write && !req_q.req_type) begin
      if (status_q == psqst_pkg::ST_NEW) fill_q <= fill_q + FILL_W'(1);
      if (handled_q != '1) handled_q <= handled_q + CNT_W'(1);
      if (lat_ok_q) lat_sum_q <= lat_add[TIME_W] ? '1 : lat_add[TIME_W-1:0];
    end
  end

  always_comb begin
    ask_vis = upd_q.ask_seen ? upd_q.ask : '0;
    spread  = '0;
    if (upd_q.bid != '0 && upd_q.ask_seen && upd_q.ask > upd_q.bid) begin
      spread = upd_q.ask - upd_q.bid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.status          <= status_q;
      result_q.symbol_out      <= upd_q.symbol;
      result_q.bid_top         <= upd_q.bid;
      result_q.ask_top         <= ask_vis;
      result_q.spread          <= spread;
      result_q.volume          <= upd_q.volume;
      result_q.msg_total       <= upd_q.count;
      result_q.processed_count <= handled_q;
      result_q.latency_total   <= lat_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== src/per_symbol_quote_stats_table_unit.sv =====
// Top level of the per-symbol quote statistics table.
// Depends on psqst_pkg; instantiates psqst_ctrl and psqst_dp.
//
//   port      dir  kind        transfer
//   req_i     in   req_t       start high while busy low
//   result_o  out  rsp_t       done_o high for one cycle
//
// An order item keeps busy high through the symbol compare, encoder group level,
// slot select, memory read, update and result register states; a report skips
// the group level. done_o is high in the first cycle with busy low, and a new
// start may be taken in that same cycle.
// Reset clears the fill count, the global counters and the controller; the
// slot memory is not cleared. The receiver cannot stall results.
module per_symbol_quote_stats_table_unit #(
  parameter int unsigned TABLE_SLOTS  = 64,
  parameter int unsigned SYMBOL_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  psqst_pkg::req_t req_i,
  output logic            done_o,
  output psqst_pkg::rsp_t result_o
);

  psqst_pkg::cmd_t cmd;
  psqst_pkg::sts_t sts;

  psqst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  psqst_dp #(
    .SLOTS     (TABLE_SLOTS),
    .SYM_BYTES (SYMBOL_BYTES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== bench/psqst_tb_pkg.sv =====
// Request and side codes shared by the quote table bench files.
// No dependencies; used by psqst_checker and tb_top.
`timescale 1ns / 1ps
package psqst_tb_pkg;

  localparam logic REQ_ORDER  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

endpackage

// ===== bench/psqst_checker.sv =====
// Watches the request and result channels of the quote statistics table,
// predicts each result from a private copy of the table and compares.
// Depends on psqst_pkg and psqst_tb_pkg.
`timescale 1ns / 1ps
module psqst_checker #(
  parameter int unsigned TABLE_SLOTS  = 64,
  parameter int unsigned SYMBOL_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  psqst_pkg::req_t   req_i,
  input  logic              done_o,
  input  psqst_pkg::rsp_t   result_o,
  output int unsigned       err_count_o,
  output int unsigned       pending_o
);
  import psqst_pkg::*;
  import psqst_tb_pkg::*;

  logic               used_q     [TABLE_SLOTS];
  logic [SYM_W-1:0]   key_q      [TABLE_SLOTS];
  logic [PRICE_W-1:0] bid_q      [TABLE_SLOTS];
  logic [PRICE_W-1:0] ask_q      [TABLE_SLOTS];
  logic               ask_seen_q [TABLE_SLOTS];
  logic [VOL_W-1:0]   vol_q      [TABLE_SLOTS];
  logic [CNT_W-1:0]   msgs_q     [TABLE_SLOTS];
  logic [CNT_W-1:0]   handled_q;
  logic [TIME_W-1:0]  lat_sum_q;

  rsp_t quotes_due_q[$];

  // Key is the symbol up to its first zero byte, at most SYMBOL_BYTES long.
  function automatic logic [SYM_W-1:0] cut_symbol(input logic [SYM_W-1:0] raw);
    logic [SYM_W-1:0] k;
    bit               stop;
    int               i;
    k    = '0;
    stop = 1'b0;
    for (i = 0; i < 8 && i < SYMBOL_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic void fill_slot(inout rsp_t r, input int s);
    r.symbol_out = key_q[s];
    r.bid_top    = bid_q[s];
    r.ask_top    = ask_seen_q[s] ? ask_q[s] : '0;
    r.spread     = '0;
    if (bid_q[s] != '0 && ask_seen_q[s] && ask_q[s] > bid_q[s])
      r.spread = ask_q[s] - bid_q[s];
    r.volume    = vol_q[s];
    r.msg_total = msgs_q[s];
  endfunction

  function automatic rsp_t predict_quote(input req_t r);
    rsp_t              e;
    logic [SYM_W-1:0]  k;
    logic [TIME_W-1:0] d;
    logic [TIME_W:0]   lsum;
    logic [VOL_W:0]    vsum;
    int                hit;
    int                free_s;
    int                s;
    e = '0;
    if (r.req_type == REQ_REPORT) begin
      if (r.slot_index < TABLE_SLOTS && used_q[r.slot_index]) begin
        e.status = ST_REPORT;
        fill_slot(e, int'(r.slot_index));
      end else begin
        e.status = ST_EMPTY;
      end
    end else begin
      k = cut_symbol(r.symbol);
      if (r.now_time >= r.send_time) begin
        d         = r.now_time - r.send_time;
        lsum      = {1'b0, lat_sum_q} + {1'b0, d};
        lat_sum_q = lsum[TIME_W] ? '1 : lsum[TIME_W-1:0];
      end
      if (handled_q != '1) handled_q = handled_q + 1'b1;
      hit    = -1;
      free_s = -1;
      for (s = 0; s < TABLE_SLOTS; s++) begin
        if (used_q[s]) begin
          if (hit < 0 && key_q[s] == k) hit = s;
        end else if (free_s < 0) begin
          free_s = s;
        end
      end
      if (hit < 0 && free_s < 0) begin
        e.status     = ST_FULL;
        e.symbol_out = k;
      end else begin
        if (hit >= 0) begin
          s        = hit;
          e.status = ST_UPDATED;
        end else begin
          s             = free_s;
          used_q[s]     = 1'b1;
          key_q[s]      = k;
          bid_q[s]      = '0;
          ask_q[s]      = '0;
          ask_seen_q[s] = 1'b0;
          vol_q[s]      = '0;
          msgs_q[s]     = '0;
          e.status      = ST_NEW;
        end
        if (msgs_q[s] != '1) msgs_q[s] = msgs_q[s] + 1'b1;
        vsum     = {1'b0, vol_q[s]} + (VOL_W + 1)'(r.quantity);
        vol_q[s] = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
        if (r.side == SIDE_BUY) begin
          if (r.price > bid_q[s]) bid_q[s] = r.price;
        end else if (!ask_seen_q[s] || r.price < ask_q[s]) begin
          ask_q[s]      = r.price;
          ask_seen_q[s] = 1'b1;
        end
        fill_slot(e, s);
      end
    end
    e.processed_count = handled_q;
    e.latency_total   = lat_sum_q;
    return e;
  endfunction

  function automatic int unsigned check_field(input string name, input logic [63:0] want,
                                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned compare_quote(input rsp_t want, input rsp_t got);
    int unsigned n;
    n = 0;
    n += check_field("status", 64'(want.status), 64'(got.status));
    n += check_field("symbol_out", want.symbol_out, got.symbol_out);
    n += check_field("bid_top", 64'(want.bid_top), 64'(got.bid_top));
    n += check_field("ask_top", 64'(want.ask_top), 64'(got.ask_top));
    n += check_field("spread", 64'(want.spread), 64'(got.spread));
    n += check_field("volume", 64'(want.volume), 64'(got.volume));
    n += check_field("msg_total", 64'(want.msg_total), 64'(got.msg_total));
    n += check_field("processed_count", 64'(want.processed_count),
                     64'(got.processed_count));
    n += check_field("latency_total", want.latency_total, got.latency_total);
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned bad;
    rsp_t        oldest;
    int          s;
    if (!rst_ni) begin
      for (s = 0; s < TABLE_SLOTS; s++) used_q[s] = 1'b0;
      handled_q = '0;
      lat_sum_q = '0;
      quotes_due_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      bad = 0;
      // A result belongs to an earlier transfer, so retire it before the new one.
      if (done_o) begin
        if (quotes_due_q.size() == 0) begin
          $display("%0t: result with none outstanding, expected nothing, got %h",
                   $time, result_o);
          bad++;
        end else begin
          oldest = quotes_due_q.pop_front();
          bad += compare_quote(oldest, result_o);
        end
      end
      if (start && !busy) quotes_due_q.push_back(predict_quote(req_i));
      err_count_o <= err_count_o + bad;
      pending_o   <= quotes_due_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the per-symbol quote statistics table.
// Depends on psqst_pkg, psqst_tb_pkg, psqst_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import psqst_pkg::*;
  import psqst_tb_pkg::*;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned POOL_N      = 96;
  localparam int unsigned POOL_EARLY  = 40;
  localparam int unsigned RAND_ITEMS  = 900;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  req_t        req_i  = '0;
  logic        busy;
  logic        done_o;
  rsp_t        result_o;
  int unsigned err_count;
  int unsigned pending;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;

  logic [SYM_W-1:0] sym_pool [POOL_N];

  per_symbol_quote_stats_table_unit #(
    .TABLE_SLOTS (SLOTS),
    .SYMBOL_BYTES(8)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  psqst_checker #(
    .TABLE_SLOTS (SLOTS),
    .SYMBOL_BYTES(8)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t junk_req();
    req_t r;
    r.req_type   = 1'($urandom);
    r.symbol     = rand64();
    r.side       = 1'($urandom);
    r.price      = $urandom;
    r.quantity   = $urandom;
    r.send_time  = rand64();
    r.now_time   = rand64();
    r.slot_index = SLOT_W'($urandom);
    return r;
  endfunction

  // Random bytes after the terminating zero must not change the key.
  function automatic logic [SYM_W-1:0] dress_symbol(input logic [SYM_W-1:0] key);
    int len;
    len = 0;
    while (len < 8 && key[8*len +: 8] != 8'h00) len++;
    if (len > 6) return key;
    return key | (rand64() & ({SYM_W{1'b1}} << (8 * (len + 1))));
  endfunction

  function automatic req_t mk_order(input logic [SYM_W-1:0] sym, input logic side,
                                    input logic [PRICE_W-1:0] price,
                                    input logic [QTY_W-1:0] qty,
                                    input logic [TIME_W-1:0] send_t,
                                    input logic [TIME_W-1:0] now_t);
    req_t r;
    r           = junk_req();
    r.req_type  = REQ_ORDER;
    r.symbol    = sym;
    r.side      = side;
    r.price     = price;
    r.quantity  = qty;
    r.send_time = send_t;
    r.now_time  = now_t;
    return r;
  endfunction

  function automatic req_t mk_report(input logic [SLOT_W-1:0] idx);
    req_t r;
    r            = junk_req();
    r.req_type   = REQ_REPORT;
    r.slot_index = idx;
    return r;
  endfunction

  function automatic req_t random_item(input int unsigned pool_used, input bit fresh_ok,
                                       input bit huge_lat);
    req_t        r;
    int unsigned m;
    logic [63:0] t;
    r = junk_req();
    if ($urandom_range(99) < 25) begin
      r.req_type = REQ_REPORT;
      return r;
    end
    r.req_type = REQ_ORDER;
    if (fresh_ok && $urandom_range(99) < 8) r.symbol = rand64();
    else r.symbol = dress_symbol(sym_pool[$urandom_range(pool_used - 1)]);
    m = $urandom_range(99);
    if (m < 40) r.price = 32'd1_000_000 + $urandom_range(2000);
    else if (m < 50) r.price = '0;
    else if (m < 60) r.price = '1;
    m = $urandom_range(99);
    if (m < 10) r.quantity = '0;
    else if (m < 20) r.quantity = '1;
    // Keep latencies small so the total only saturates in the last few items.
    m = $urandom_range(99);
    if (huge_lat) begin
      r.send_time = 64'($urandom_range(1000));
      r.now_time  = '1;
    end else if (m < 70) begin
      r.now_time = r.send_time + 64'($urandom_range(5000));
    end else if (m < 80) begin
      r.now_time = r.send_time;
    end else if (r.now_time > r.send_time) begin
      t           = r.now_time;
      r.now_time  = r.send_time;
      r.send_time = t;
    end
    return r;
  endfunction

  // Holds start off for a random gap, then keeps it up until the transfer.
  task automatic issue(input req_t r);
    int unsigned gap;
    gap = 0;
    if (idle_en) while ($urandom_range(99) < 19) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      req_i <= junk_req();
      // let the previous transfer finish so the gap lands where one could be taken
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat (gap - 1) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned      i;
    int               b;
    int               len;
    logic [SYM_W-1:0] k;
    localparam logic [SYM_W-1:0] SYM_ABCD      = 64'h0000_0000_4443_4241;
    localparam logic [SYM_W-1:0] SYM_ABCD_TAIL = 64'h7A79_7800_4443_4241;
    localparam logic [SYM_W-1:0] SYM_WXYZ      = 64'h0000_0000_5A59_5857;
    localparam logic [SYM_W-1:0] SYM_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [SYM_W-1:0] SYM_HIGH      = 64'h8080_8080_8080_8080;

    // Distinct keys: first byte is the pool index, entry 0 is the empty key.
    sym_pool[0] = '0;
    for (i = 1; i < POOL_N; i++) begin
      len = $urandom_range(8, 1);
      k   = '0;
      k[7:0] = 8'(i);
      for (b = 1; b < len; b++) k[8*b +: 8] = 8'($urandom_range(255, 1));
      sym_pool[i] = k;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(mk_report(6'd0));
    issue(mk_report(6'd63));
    issue(mk_order(SYM_ABCD, SIDE_BUY, 32'd1_500_000, 32'd100, 64'd1000, 64'd1250));
    issue(mk_order(SYM_ABCD, SIDE_SELL, 32'd1_500_500, '1, 64'd2000, 64'd2000));
    // ask below bid: spread clamps to zero; now before send adds no latency
    issue(mk_order(SYM_ABCD, SIDE_SELL, 32'd1_499_000, '0, 64'd3000, 64'd2999));
    issue(mk_order(SYM_ABCD, SIDE_BUY, '0, 32'd5, 64'd10, 64'd20));
    issue(mk_report(6'd0));
    issue(mk_order(SYM_ABCD_TAIL, SIDE_BUY, 32'd1_600_000, 32'd7, 64'd30, 64'd31));
    issue(mk_order(64'd0, SIDE_SELL, '0, 32'd1, 64'd40, 64'd45));
    issue(mk_order(SYM_ONES, SIDE_BUY, '1, '1, '1, 64'd0));
    issue(mk_order(SYM_ONES, SIDE_SELL, '1, 32'd2, 64'd50, 64'd60));
    issue(mk_order(SYM_HIGH, SIDE_BUY, 32'd1, 32'd3, 64'd70, 64'd70));
    issue(mk_order(SYM_HIGH, SIDE_SELL, 32'd2, 32'd4, 64'd80, 64'd81));
    issue(mk_order(SYM_WXYZ, SIDE_SELL, 32'd7, 32'd9, 64'd90, 64'd99));
    issue(mk_order(SYM_WXYZ, SIDE_BUY, 32'd3, 32'd9, 64'd100, 64'd101));
    issue(mk_order(SYM_WXYZ, SIDE_SELL, '0, 32'd9, 64'd110, 64'd111));
    for (i = 1; i < 7; i++) issue(mk_report(SLOT_W'(i)));

    for (i = 0; i < RAND_ITEMS; i++) begin
      idle_en = !(i >= 300 && i < 450);
      // later items widen the key set so the table fills and drops updates
      issue(random_item(i < 550 ? POOL_EARLY : POOL_N, i >= 550, i >= RAND_ITEMS - 4));
    end
    start <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
